/* rtl/core/pdr_pkg.sv */
// ----------------------------------------------------------------------------
// pdr_pkg
// Shared types and constants for the dead-reckoning pose update.
// ----------------------------------------------------------------------------
package pdr_pkg;

  localparam int DIST_W = 25;
  localparam int TRIG_W = 33;
  localparam int PROD_W = 58;
  localparam int STEP_W = 5;
  localparam int POS_EXT_W = 34;
  localparam int ADDR_W = 3;

  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [31:0] ATAN_TURN32 [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic REG_POS_LIMIT = 1'b0;
  localparam logic REG_HDG_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL,
    ST_COMMIT
  } pdr_state_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_val;
    logic signed [TRIG_W-1:0] sin_val;
  } cordic_res_t;

  // atan table entry rounded half up to the chosen angle width
  function automatic logic [31:0] atan_round(logic [STEP_W-1:0] i, int unsigned sh);
    return (ATAN_TURN32[i] + (32'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

/* rtl/core/pdr_if.sv */
// ----------------------------------------------------------------------------
// pdr_if
// Request and result channels of the pose update.
// ----------------------------------------------------------------------------
interface pdr_odo_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [23:0] travel_length;
  logic signed [15:0] travel_direction;
  logic signed [15:0] turn_angle;
  logic signed [23:0] length_noise;
  logic signed [15:0] angle_noise;
  logic signed [31:0] load_x;
  logic signed [31:0] load_y;
  logic [15:0]        load_heading;

  modport source (output valid, mode, travel_length, travel_direction, turn_angle,
                  length_noise, angle_noise, load_x, load_y, load_heading,
                  input ready);
  modport sink (input valid, mode, travel_length, travel_direction, turn_angle,
                length_noise, angle_noise, load_x, load_y, load_heading,
                output ready);
endinterface

interface pdr_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic [15:0]        pose_heading;
  logic               near_zero;
  logic               saturated;

  modport source (output valid, pose_x, pose_y, pose_heading, near_zero, saturated,
                  input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, near_zero, saturated,
                output ready);
endinterface

/* rtl/core/pdr_cordic.sv */
// ----------------------------------------------------------------------------
// pdr_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module pdr_cordic #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [15:0]         angle,
  output pdr_pkg::cordic_res_t res
);
  import pdr_pkg::*;

  localparam int AW = ANGLE_BITS + 2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (ANGLE_BITS - 2);

  logic [ANGLE_BITS-1:0]    a_u;
  logic signed [AW-1:0]     a_s;
  logic signed [AW-1:0]     a_fold;
  logic                     neg_fold;
  logic signed [AW-1:0]     ang;
  logic signed [AW-1:0]     e;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic [STEP_W-1:0]        cnt;
  logic                     busy;
  logic                     neg;
  logic                     fin;

  assign a_u = ANGLE_BITS'({angle, 8'h00} >> (24 - ANGLE_BITS));
  assign a_s = AW'($signed(a_u));

  always_comb begin
    a_fold = a_s;
    neg_fold = 1'b0;
    if (a_s > QUARTER) begin
      a_fold = a_s - HALF;
      neg_fold = 1'b1;
    end else if (a_s < -QUARTER) begin
      a_fold = a_s + HALF;
      neg_fold = 1'b1;
    end
  end

  assign e = AW'(atan_round(cnt, 32 - ANGLE_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= '0;
      ang <= a_fold;
      neg <= neg_fold;
    end else if (busy) begin
      if (ang >= 0) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        ang <= ang - e;
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        ang <= ang + e;
      end
    end
  end

  assign res.done = fin;
  assign res.cos_val = neg ? -x : x;
  assign res.sin_val = neg ? -y : y;

endmodule

/* rtl/core/pdr_serial_mul.sv */
// ----------------------------------------------------------------------------
// pdr_serial_mul
// Bit-serial signed multiplier: distance times Q30 factor, rounded to Q16.16.
// ----------------------------------------------------------------------------
module pdr_serial_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [pdr_pkg::DIST_W-1:0] distance,
  input  logic signed [pdr_pkg::TRIG_W-1:0] factor,
  output logic                             done,
  output logic signed [pdr_pkg::POS_EXT_W-1:0] product
);
  import pdr_pkg::*;

  logic signed [PROD_W-1:0] acc;
  logic signed [PROD_W-1:0] mcand;
  logic [DIST_W-1:0]        dsh;
  logic [STEP_W-1:0]        cnt;
  logic                     busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(DIST_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // sign bit of the distance carries negative weight
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= PROD_W'(1) <<< 29;
      mcand <= PROD_W'(factor);
      dsh <= distance;
    end else if (busy) begin
      if (dsh[0]) begin
        if (cnt == STEP_W'(DIST_W - 1)) begin
          acc <= acc - mcand;
        end else begin
          acc <= acc + mcand;
        end
      end
      mcand <= mcand <<< 1;
      dsh <= dsh >> 1;
    end
  end

  assign product = POS_EXT_W'($signed(acc[PROD_W-1:30]));

endmodule

/* rtl/core/pose_dead_reckoning_update.sv */
// ----------------------------------------------------------------------------
// pose_dead_reckoning_update
// One request at a time; a move request passes through the iterative CORDIC
// (one step a cycle) and then the bit-serial multiply.
// A new request is taken while the previous result waits in the output register.
// Reset: pose cleared to zero, limits to 66 and 10, no result pending.
// ----------------------------------------------------------------------------
module pose_dead_reckoning_update #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  pdr_odo_if.sink                    odo,
  pdr_pose_if.source                 pose,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pdr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pdr_pkg::*;

  pdr_state_t state;
  pdr_state_t state_next;

  logic [15:0] pos_limit;
  logic [14:0] hdg_limit;

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;

  logic                     ld_mode;
  logic signed [DIST_W-1:0] distance;
  logic [15:0]              turn_sum;
  logic signed [31:0]       ld_x;
  logic signed [31:0]       ld_y;
  logic [15:0]              ld_heading;

  logic        accept;
  logic        cordic_start;
  logic        mul_start;
  logic        commit;
  logic [15:0] phi;

  cordic_res_t                 cres;
  logic                        mul_done_x;
  logic                        mul_done_y;
  logic signed [POS_EXT_W-1:0] px;
  logic signed [POS_EXT_W-1:0] py;

  logic signed [POS_EXT_W-1:0] sum_x;
  logic signed [POS_EXT_W-1:0] sum_y;
  logic                        sat_x;
  logic                        sat_y;
  logic signed [31:0]          x_next;
  logic signed [31:0]          y_next;
  logic [15:0]                 heading_next;
  logic [32:0]                 abs_x;
  logic [32:0]                 abs_y;
  logic [15:0]                 abs_h;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_limit <= 16'd66;
      hdg_limit <= 15'd10;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_POS_LIMIT: pos_limit <= pwdata[15:0];
        REG_HDG_LIMIT: hdg_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POS_LIMIT: prdata = {16'h0000, pos_limit};
      REG_HDG_LIMIT: prdata = {17'd0, hdg_limit};
      default: prdata = '0;
    endcase
  end

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (odo.valid) begin
          state_next = odo.mode ? ST_COMMIT : ST_CORDIC;
        end
      end
      ST_CORDIC: begin
        if (cres.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done_x) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!pose.valid || pose.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    odo.ready = 1'b0;
    cordic_start = 1'b0;
    mul_start = 1'b0;
    commit = 1'b0;
    unique case (state)
      ST_IDLE: begin
        odo.ready = 1'b1;
        cordic_start = odo.valid && !odo.mode;
      end
      ST_CORDIC: mul_start = cres.done;
      ST_MUL: ;
      ST_COMMIT: commit = !pose.valid || pose.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = odo.valid && odo.ready;
  assign phi = 16'(odo.travel_direction) + 16'(odo.angle_noise) + heading;

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_mode <= odo.mode;
      distance <= DIST_W'(odo.travel_length) + DIST_W'(odo.length_noise);
      turn_sum <= 16'(odo.turn_angle) + 16'(odo.angle_noise);
      ld_x <= odo.load_x;
      ld_y <= odo.load_y;
      ld_heading <= odo.load_heading;
    end
  end

  pdr_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS),
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk(clk),
    .rst(rst),
    .start(cordic_start),
    .angle(phi),
    .res(cres)
  );

  pdr_serial_mul u_mul_x (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .distance(distance),
    .factor(cres.cos_val),
    .done(mul_done_x),
    .product(px)
  );

  pdr_serial_mul u_mul_y (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .distance(distance),
    .factor(cres.sin_val),
    .done(mul_done_y),
    .product(py)
  );

  // saturating position update
  assign sum_x = POS_EXT_W'(pos_x) + px;
  assign sum_y = POS_EXT_W'(pos_y) + py;
  assign sat_x = (sum_x[POS_EXT_W-1:31] != '0) && (sum_x[POS_EXT_W-1:31] != '1);
  assign sat_y = (sum_y[POS_EXT_W-1:31] != '0) && (sum_y[POS_EXT_W-1:31] != '1);

  always_comb begin
    if (ld_mode) begin
      x_next = ld_x;
      y_next = ld_y;
      heading_next = ld_heading;
    end else begin
      x_next = sat_x ? (sum_x[POS_EXT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : sum_x[31:0];
      y_next = sat_y ? (sum_y[POS_EXT_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                     : sum_y[31:0];
      heading_next = heading + turn_sum;
    end
  end

  assign abs_x = x_next[31] ? -33'(x_next) : 33'(x_next);
  assign abs_y = y_next[31] ? -33'(y_next) : 33'(y_next);
  assign abs_h = heading_next[15] ? -heading_next : heading_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      heading <= '0;
      pose.valid <= 1'b0;
    end else begin
      if (pose.valid && pose.ready) begin
        pose.valid <= 1'b0;
      end
      if (commit) begin
        pos_x <= x_next;
        pos_y <= y_next;
        heading <= heading_next;
        pose.valid <= 1'b1;
      end
    end
  end

  // most negative heading has abs_h[15] set and never counts as near zero
  always_ff @(posedge clk) begin
    if (commit) begin
      pose.pose_x <= x_next;
      pose.pose_y <= y_next;
      pose.pose_heading <= heading_next;
      pose.near_zero <= (abs_x < 33'(pos_limit)) && (abs_y < 33'(pos_limit)) &&
                        (abs_h < 16'(hdg_limit));
      pose.saturated <= !ld_mode && (sat_x || sat_y);
    end
  end

  a_cordic_in_state: assert property (@(posedge clk) disable iff (rst)
    cres.done |-> state == ST_CORDIC)
    else $error("cordic finished outside its phase");

  a_mul_in_state: assert property (@(posedge clk) disable iff (rst)
    mul_done_x |-> state == ST_MUL && mul_done_y)
    else $error("multipliers out of step");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> pose.valid && state == ST_IDLE)
    else $error("committed result not presented");

endmodule

/* tb/tb_pose_dead_reckoning_update.sv */
// ----------------------------------------------------------------------------
// tb_pose_dead_reckoning_update
// Drives load and move requests with random gaps and stalls, predicts each
// pose with a bit-true CORDIC dead-reckoning model and checks every field.
// ----------------------------------------------------------------------------
module tb_pose_dead_reckoning_update;
  import pdr_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS = 16;
  localparam int MOVE_LATENCY = CORDIC_STEPS + 29;
  localparam int STALL_LIMIT = 20000;
  localparam logic MODE_MOVE = 1'b0;
  localparam logic MODE_LOAD = 1'b1;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        hdg;
    logic               nz;
    logic               sat;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  pdr_odo_if odo ();
  pdr_pose_if pose ();

  pose_dead_reckoning_update #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) dut (
    .clk(clk), .rst(rst), .odo(odo.sink), .pose(pose.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic signed [31:0] cur_x, cur_y;
  logic [15:0] cur_hdg;
  logic [15:0] pos_limit;
  logic [14:0] hdg_limit;
  pose_t expected_poses[$];

  int gap_pct = 0, stall_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint asr64(longint v, int s);
    return v >>> s;
  endfunction

  function automatic void cordic_trig(input logic [15:0] ang, output longint c,
                                      output longint s);
    longint full, half, quarter, a, x, y, dx, dy, e, t;
    bit neg;
    full = 64'sd1 << ANGLE_BITS;
    half = full / 2;
    quarter = full / 4;
    x = 652032874;
    y = 0;
    neg = 0;
    a = longint'(ang) << (ANGLE_BITS - 16);
    if (a >= half) a -= full;
    if (a > quarter) begin
      a -= half;
      neg = 1;
    end else if (a < -quarter) begin
      a += half;
      neg = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = asr64(y, i);
      dy = asr64(x, i);
      t = longint'(ATAN_TURN32[i]);
      e = (t + (64'sd1 << (32 - ANGLE_BITS - 1))) >> (32 - ANGLE_BITS);
      if (a >= 0) begin
        x -= dx; y += dy; a -= e;
      end else begin
        x += dx; y -= dy; a += e;
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic signed [31:0] clip_add(logic signed [31:0] p, longint d,
                                                  inout bit sat);
    longint r;
    r = longint'(p) + d;
    if (r > 64'sd2147483647) begin
      sat = 1;
      return 32'sh7FFFFFFF;
    end
    if (r < -64'sd2147483648) begin
      sat = 1;
      return 32'sh80000000;
    end
    return r[31:0];
  endfunction

  function automatic pose_t predict_pose(logic m, logic signed [23:0] len,
      logic signed [15:0] dir, logic signed [15:0] turn, logic signed [23:0] lnoise,
      logic signed [15:0] anoise, logic signed [31:0] lx, logic signed [31:0] ly,
      logic [15:0] lh);
    pose_t p;
    bit sat;
    longint d, c, s, ax, ay, ah;
    logic [15:0] phi;
    sat = 0;
    if (m == MODE_LOAD) begin
      cur_x = lx;
      cur_y = ly;
      cur_hdg = lh;
    end else begin
      d = longint'(len) + longint'(lnoise);
      phi = dir + anoise + cur_hdg;
      cordic_trig(phi, c, s);
      cur_x = clip_add(cur_x, asr64(d * c + (64'sd1 << 29), 30), sat);
      cur_y = clip_add(cur_y, asr64(d * s + (64'sd1 << 29), 30), sat);
      cur_hdg = cur_hdg + turn + anoise;
    end
    ax = cur_x < 0 ? -longint'(cur_x) : longint'(cur_x);
    ay = cur_y < 0 ? -longint'(cur_y) : longint'(cur_y);
    ah = longint'($signed(cur_hdg));
    if (ah < 0) ah = -ah;
    p.x = cur_x;
    p.y = cur_y;
    p.hdg = cur_hdg;
    p.nz = (ax < pos_limit) && (ay < pos_limit) && (ah < hdg_limit);
    p.sat = sat;
    return p;
  endfunction

  task automatic send_request(logic m, logic signed [23:0] len, logic signed [15:0] dir,
      logic signed [15:0] turn, logic signed [23:0] lnoise, logic signed [15:0] anoise,
      logic signed [31:0] lx, logic signed [31:0] ly, logic [15:0] lh);
    while ($urandom_range(99) < gap_pct) begin
      odo.valid <= 1'b0;
      @(posedge clk);
    end
    odo.valid <= 1'b1;
    odo.mode <= m;
    odo.travel_length <= len;
    odo.travel_direction <= dir;
    odo.turn_angle <= turn;
    odo.length_noise <= lnoise;
    odo.angle_noise <= anoise;
    odo.load_x <= lx;
    odo.load_y <= ly;
    odo.load_heading <= lh;
    do @(posedge clk); while (!odo.ready);
    expected_poses.push_back(predict_pose(m, len, dir, turn, lnoise, anoise, lx, ly, lh));
  endtask

  task automatic send_move(logic signed [23:0] len, logic signed [15:0] dir,
      logic signed [15:0] turn, logic signed [23:0] lnoise, logic signed [15:0] anoise);
    send_request(MODE_MOVE, len, dir, turn, lnoise, anoise, $urandom, $urandom,
                 16'($urandom));
  endtask

  task automatic send_load(logic signed [31:0] lx, logic signed [31:0] ly, logic [15:0] lh);
    send_request(MODE_LOAD, 24'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                 16'($urandom), lx, ly, lh);
  endtask

  task automatic drain();
    odo.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (MOVE_LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_limit(logic idx, logic [31:0] val);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_POS_LIMIT) pos_limit = val[15:0];
    else hdg_limit = val[14:0];
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      pose.ready <= ($urandom_range(99) >= stall_pct);
      if (pose.valid && pose.ready) begin
        if (expected_poses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pose x=%0d y=%0d", pose.pose_x, pose.pose_y);
        end else begin
          pose_t e;
          e = expected_poses.pop_front();
          if (pose.pose_x !== e.x || pose.pose_y !== e.y || pose.pose_heading !== e.hdg ||
              pose.near_zero !== e.nz || pose.saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"pose mismatch: exp x=%0d y=%0d h=%0d nz=%0b sat=%0b, ",
                        "got x=%0d y=%0d h=%0d nz=%0b sat=%0b"},
                       e.x, e.y, e.hdg, e.nz, e.sat, pose.pose_x, pose.pose_y,
                       pose.pose_heading, pose.near_zero, pose.saturated);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((odo.valid && odo.ready) || (pose.valid && pose.ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_pose_dead_reckoning_update: FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    send_move(24'sd65536, 16'sd0, 16'sd0, 24'sd0, 16'sd0);
    send_move(24'sd65536, 16'sd16384, 16'sd100, 24'sd0, 16'sd0);
    send_move(-24'sd8388608, -16'sd32768, -16'sd32768, -24'sd8388608, -16'sd32768);
    send_move(24'sd8388607, 16'sd32767, 16'sd32767, 24'sd8388607, 16'sd32767);
    send_load(32'sd0, 32'sd0, 16'd0);
    send_load(32'sd65, -32'sd65, 16'd9);
    send_load(32'sd66, 32'sd0, 16'd65527);
    send_load(32'sd0, 32'sd0, 16'd32768);
    send_load(32'sh7FFFFF00, 32'sh80000100, 16'd0);
    send_move(24'sd8388607, 16'sd0, 16'sd0, 24'sd8388607, 16'sd0);
    send_move(24'sd8388607, -16'sd16384, 16'sd0, 24'sd8388607, 16'sd0);
    send_load(32'sh80000000, 32'sh7FFFFFFF, 16'd65535);
    send_move(-24'sd8388608, 16'sd0, 16'sd0, -24'sd8388608, 16'sd0);
    send_move(24'sd4096, 16'sd8192, -16'sd8192, 24'sd0, 16'sd0);
    send_move(24'sd4096, -16'sd8193, 16'sd5, 24'sd7, -16'sd1);
    send_load(32'sd0, 32'sd0, 16'd0);
    send_move(24'sd0, 16'sd0, 16'sd0, 24'sd0, 16'sd0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: send_load($urandom, $urandom, 16'($urandom));
        1: send_load(32'($signed($urandom_range(200)) - 100),
                     32'($signed($urandom_range(200)) - 100),
                     16'($urandom_range(40)) - 16'd20);
        2: send_move(24'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                     16'($urandom));
        default: send_move(24'($signed($urandom_range(131072)) - 65536), 16'($urandom),
                           16'($urandom), 24'($signed($urandom_range(64)) - 32),
                           16'($signed($urandom_range(64)) - 32));
      endcase
    end
  endtask

  task automatic test_limits();
    write_limit(REG_POS_LIMIT, 32'd0);
    write_limit(REG_HDG_LIMIT, 32'd0);
    test_random(60);
    write_limit(REG_POS_LIMIT, 32'hFFFFFFFF);
    write_limit(REG_HDG_LIMIT, 32'hFFFFFFFF);
    send_load(32'sd0, 32'sd0, 16'd32768);
    send_load(-32'sd65534, 32'sd65534, 16'd32769);
    test_random(60);
    write_limit(REG_POS_LIMIT, 32'd500);
    write_limit(REG_HDG_LIMIT, 32'd300);
  endtask

  task automatic test_idling();
    gap_pct = 61; stall_pct = 0;  test_random(280);
    drain();
    gap_pct = 0;  stall_pct = 61; test_random(280);
    gap_pct = 21; stall_pct = 21; test_random(280);
    gap_pct = 0;  stall_pct = 0;  test_random(300);
  endtask

  initial begin
    odo.valid = 1'b0;
    odo.mode = MODE_MOVE;
    odo.travel_length = '0;
    odo.travel_direction = '0;
    odo.turn_angle = '0;
    odo.length_noise = '0;
    odo.angle_noise = '0;
    odo.load_x = '0;
    odo.load_y = '0;
    odo.load_heading = '0;
    pose.ready = 1'b0;
    cur_x = '0;
    cur_y = '0;
    cur_hdg = '0;
    pos_limit = 16'd66;
    hdg_limit = 15'd10;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_limits();
    test_idling();
    drain();
    if (mismatches == 0 && expected_poses.size() == 0)
      $display("tb_pose_dead_reckoning_update: PASS");
    else
      $display("tb_pose_dead_reckoning_update: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/pdr_pkg.sv
rtl/core/pdr_if.sv
rtl/core/pdr_cordic.sv
rtl/core/pdr_serial_mul.sv
rtl/core/pose_dead_reckoning_update.sv
tb/tb_pose_dead_reckoning_update.sv
